// File: rtl/core/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_YIELD     = 3'd1,
        OP_SLEEP     = 3'd2,
        OP_OBTAIN    = 3'd3,
        OP_OBTAIN_TO = 3'd4,
        OP_RELEASE   = 3'd5,
        OP_CREATE    = 3'd6,
        OP_KILL      = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_LAST_KEPT = 3'd3,
        ST_NONE_RUN  = 3'd4
    } status_t;

    localparam logic [2:0] MODE_RUN   = 3'd0;
    localparam logic [2:0] MODE_NEW   = 3'd1;
    localparam logic [2:0] MODE_BLOCK = 3'd2;
    localparam logic [2:0] MODE_WAIT  = 3'd4;
    localparam logic [2:0] MODE_BTO   = 3'd6;

    localparam int unsigned PID_BITS = 15;
    localparam logic [PID_BITS-1:0] PID_MAX = 15'h7FFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK,
        S_YIELD,
        S_CREATE_SLOT,
        S_CREATE_PID,
        S_CREATE_CHECK,
        S_CREATE_LINK,
        S_KILL_FIND,
        S_KILL_PRED,
        S_KILL_LINK,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: sequencer and task table.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | opcode, delay_ms, sem_index, target_pid
//  out     | output    | out_valid/out_stall | status, current_pid, switched,
//          |           |                  | started_new, new_pid
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (multitask_enable)
//
// A word steps from dispatch through its work states to done and back to idle; the
// work of a tick, a yield, a kill or a create is set by the slot walk: every step of a
// tick sweep, ring walk, pid search or predecessor search visits one slot through a
// single shared compare path. A create with pid collisions repeats the pid search.
// Reset clears all control state at once; no clearing pass. in_stall is high while a
// word is being worked on; a stalled result holds in the output register, and the
// next word waits in its done step until that result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS      = 16,
    parameter int NUM_SEMAPHORES = 16,
    parameter int TIME_BITS      = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [2:0]          opcode,
    input  wire logic [31:0]         delay_ms,
    input  wire logic [3:0]          sem_index,
    input  wire logic [PID_BITS-1:0] target_pid,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [2:0]               status,
    output logic [PID_BITS-1:0]      current_pid,
    output logic                     switched,
    output logic                     started_new,
    output logic [PID_BITS-1:0]      new_pid,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int MW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int CW = $clog2(MAX_TASKS + 2);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TASKS - 1);

    // Slot table: small, indexed by the walking pointer, the current slot and the free or kill slot.
    logic [MAX_TASKS-1:0] used_reg;
    logic [2:0]           mode_reg  [MAX_TASKS];
    logic [TIME_BITS-1:0] wake_reg  [MAX_TASKS];
    logic [MW-1:0]        blk_reg   [MAX_TASKS];
    logic [PID_BITS-1:0]  pid_reg   [MAX_TASKS];
    logic [SW-1:0]        link_reg  [MAX_TASKS];
    logic [NUM_SEMAPHORES-1:0] sem_reg;

    logic                 en_reg;
    logic [SW-1:0]        cur_reg;
    logic                 have_reg;
    logic [TIME_BITS-1:0] clk_ms_reg;
    logic [PID_BITS-1:0]  last_pid_reg;

    state_t               st_reg, st_next;
    op_t                  op_reg;
    logic [TIME_BITS-1:0] delay_reg;
    logic [MW-1:0]        sem_idx_reg;
    logic [PID_BITS-1:0]  tpid_reg;
    logic                 had_reg;
    logic [SW-1:0]        before_reg;

    logic [SW-1:0]        ptr_reg;    // walking slot
    logic [SW-1:0]        aux_reg;    // free slot / kill target
    logic [CW-1:0]        cnt_reg;    // step counter
    logic [CW-1:0]        tries_reg;  // pid tries
    logic                 started_reg;
    logic [2:0]           status_reg;
    logic [PID_BITS-1:0]  newpid_reg;

    logic                 out_valid_reg;
    logic [2:0]           o_status_reg;
    logic [PID_BITS-1:0]  o_cur_reg, o_new_reg;
    logic                 o_sw_reg, o_start_reg;

    logic in_fire, out_fire, out_free;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    // Output register is free for a new result word at this edge.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (st_reg != S_IDLE);
    assign cfg_ready = (st_reg == S_IDLE);

    assign out_valid   = out_valid_reg;
    assign status      = o_status_reg;
    assign current_pid = o_cur_reg;
    assign switched    = o_sw_reg;
    assign started_new = o_start_reg;
    assign new_pid     = o_new_reg;

    // Shared per-slot view of the walking pointer.
    logic [2:0]           p_mode;
    logic [SW-1:0]        p_link;
    logic                 p_used;
    logic                 p_sem_set;
    logic                 last_step;
    logic [PID_BITS-1:0]  pid_cand;
    assign p_mode    = mode_reg[ptr_reg];
    assign p_link    = link_reg[ptr_reg];
    assign p_used    = used_reg[ptr_reg];
    assign p_sem_set = sem_reg[blk_reg[ptr_reg]];
    assign last_step = (cnt_reg == CW'(MAX_TASKS - 1));
    assign pid_cand  = (last_pid_reg == PID_MAX) ? PID_BITS'(1) : last_pid_reg + 1'b1;

    logic [TIME_BITS-1:0] wake_sum;
    assign wake_sum = clk_ms_reg + delay_reg;

    logic [MW-1:0] sem_in;
    assign sem_in = MW'(sem_index % NUM_SEMAPHORES);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:         if (in_fire) st_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_TICK:   st_next = en_reg ? S_TICK : S_DONE;
                    OP_CREATE: st_next = S_CREATE_SLOT;
                    OP_KILL:   st_next = S_KILL_FIND;
                    default:   st_next = (have_reg && en_reg) ? S_YIELD : S_DONE;
                endcase
            end
            S_TICK:         if (last_step) st_next = S_DONE;
            S_YIELD:
            begin
                if (p_mode == MODE_RUN || p_mode == MODE_NEW ||
                    (p_mode[1] && !p_sem_set) || last_step)
                    st_next = S_DONE;
            end
            S_CREATE_SLOT:
            begin
                if (!p_used)
                    st_next = (last_pid_reg == '0) ? S_CREATE_LINK : S_CREATE_PID;
                else if (last_step)
                    st_next = S_DONE;
            end
            S_CREATE_PID:   st_next = S_CREATE_CHECK;
            S_CREATE_CHECK:
            begin
                if (p_used && pid_reg[ptr_reg] == last_pid_reg)
                    st_next = (tries_reg == CW'(MAX_TASKS)) ? S_CREATE_LINK
                                                            : S_CREATE_PID;
                else if (last_step)
                    st_next = S_CREATE_LINK;
            end
            S_CREATE_LINK:  st_next = S_DONE;
            S_KILL_FIND:
            begin
                if (tpid_reg == '0)
                    st_next = S_DONE;
                else if (p_used && pid_reg[ptr_reg] == tpid_reg)
                    st_next = (p_link == ptr_reg) ? S_DONE : S_KILL_PRED;
                else if (last_step)
                    st_next = S_DONE;
            end
            S_KILL_PRED:    if (p_link == aux_reg || last_step) st_next = S_KILL_LINK;
            S_KILL_LINK:    st_next = S_DONE;
            // Hold the finished word until the output register can take it.
            S_DONE:         if (out_free) st_next = S_IDLE;
            default:        st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            en_reg        <= 1'b0;
            used_reg      <= '0;
            sem_reg       <= '0;
            cur_reg       <= '0;
            have_reg      <= 1'b0;
            clk_ms_reg    <= '0;
            last_pid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready)
                en_reg <= cfg_data;
            if (st_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;

            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg      <= op_t'(opcode);
                        delay_reg   <= TIME_BITS'(delay_ms);
                        sem_idx_reg <= sem_in;
                        tpid_reg    <= target_pid;
                        had_reg     <= have_reg;
                        before_reg  <= cur_reg;
                        started_reg <= 1'b0;
                        status_reg  <= ST_OK;
                        newpid_reg  <= '0;
                        cnt_reg     <= '0;
                    end
                end
                S_DISPATCH:
                begin
                    cnt_reg <= '0;
                    unique case (op_reg)
                        OP_TICK:
                        begin
                            clk_ms_reg <= clk_ms_reg + 1'b1;
                            ptr_reg    <= '0;
                        end
                        OP_CREATE, OP_KILL: ptr_reg <= '0;
                        default:
                        begin
                            ptr_reg <= link_reg[cur_reg];
                            if (op_reg == OP_SLEEP && have_reg)
                            begin
                                wake_reg[cur_reg] <= wake_sum;
                                mode_reg[cur_reg] <= MODE_WAIT;
                            end
                            if (op_reg == OP_OBTAIN || op_reg == OP_OBTAIN_TO)
                            begin
                                sem_reg[sem_idx_reg] <= 1'b1;
                                if (have_reg)
                                begin
                                    blk_reg[cur_reg] <= sem_idx_reg;
                                    if (op_reg == OP_OBTAIN_TO)
                                    begin
                                        wake_reg[cur_reg] <= wake_sum;
                                        mode_reg[cur_reg] <= MODE_BTO;
                                    end
                                    else
                                        mode_reg[cur_reg] <= MODE_BLOCK;
                                end
                            end
                            if (!have_reg)
                                status_reg <= ST_NONE_RUN;
                            // Self-selection of a link out of range cannot occur.
                            if (have_reg && link_reg[cur_reg] > LAST_SLOT)
                                ptr_reg <= '0;
                        end
                    endcase
                end
                S_TICK:
                begin
                    if (p_used && p_mode[2] && clk_ms_reg >= wake_reg[ptr_reg])
                        mode_reg[ptr_reg] <= MODE_RUN;
                    ptr_reg <= ptr_reg + 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_YIELD:
                begin
                    if (p_mode == MODE_RUN)
                        cur_reg <= ptr_reg;
                    else if (p_mode == MODE_NEW)
                    begin
                        mode_reg[ptr_reg] <= MODE_RUN;
                        started_reg       <= 1'b1;
                        cur_reg           <= ptr_reg;
                    end
                    else if (p_mode[1] && !p_sem_set)
                    begin
                        mode_reg[ptr_reg] <= MODE_RUN;
                        cur_reg           <= ptr_reg;
                    end
                    else
                    begin
                        if (last_step)
                            status_reg <= ST_NONE_RUN;
                        ptr_reg <= p_link;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_CREATE_SLOT:
                begin
                    if (!p_used)
                    begin
                        aux_reg   <= ptr_reg;
                        tries_reg <= '0;
                        if (last_pid_reg == '0)
                            last_pid_reg <= PID_BITS'(1);
                    end
                    else
                    begin
                        if (last_step)
                            status_reg <= ST_FULL;
                        ptr_reg <= ptr_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_CREATE_PID:
                begin
                    last_pid_reg <= pid_cand;
                    tries_reg    <= tries_reg + 1'b1;
                    ptr_reg      <= '0;
                    cnt_reg      <= '0;
                end
                S_CREATE_CHECK:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_CREATE_LINK:
                begin
                    used_reg[aux_reg] <= 1'b1;
                    mode_reg[aux_reg] <= MODE_NEW;
                    wake_reg[aux_reg] <= '0;
                    blk_reg[aux_reg]  <= '0;
                    pid_reg[aux_reg]  <= last_pid_reg;
                    newpid_reg        <= last_pid_reg;
                    if (!have_reg)
                    begin
                        cur_reg           <= aux_reg;
                        link_reg[aux_reg] <= aux_reg;
                        have_reg          <= 1'b1;
                    end
                    else
                    begin
                        link_reg[aux_reg] <= link_reg[cur_reg];
                        link_reg[cur_reg] <= aux_reg;
                    end
                end
                S_KILL_FIND:
                begin
                    if (tpid_reg == '0)
                        status_reg <= ST_NOT_FOUND;
                    else if (p_used && pid_reg[ptr_reg] == tpid_reg)
                    begin
                        aux_reg <= ptr_reg;
                        cnt_reg <= '0;
                        if (p_link == ptr_reg)
                            status_reg <= ST_LAST_KEPT;
                    end
                    else
                    begin
                        if (last_step)
                            status_reg <= ST_NOT_FOUND;
                        ptr_reg <= ptr_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_KILL_PRED:
                begin
                    if (!(p_link == aux_reg || last_step))
                    begin
                        ptr_reg <= p_link;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_KILL_LINK:
                begin
                    link_reg[ptr_reg] <= link_reg[aux_reg];
                    used_reg[aux_reg] <= 1'b0;
                    if (cur_reg == aux_reg)
                    begin
                        cur_reg <= link_reg[aux_reg];
                        if (mode_reg[link_reg[aux_reg]] == MODE_NEW)
                        begin
                            mode_reg[link_reg[aux_reg]] <= MODE_RUN;
                            started_reg                 <= 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        if (op_reg == OP_RELEASE)
                            sem_reg[sem_idx_reg] <= 1'b0;
                        o_status_reg  <= status_reg;
                        o_cur_reg     <= have_reg ? pid_reg[cur_reg] : '0;
                        o_sw_reg      <= (had_reg != have_reg) ||
                                         (have_reg && before_reg != cur_reg);
                        o_start_reg   <= started_reg;
                        o_new_reg     <= newpid_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/rrts_checker.sv
// Port-level checker for the round-robin task scheduler, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rrts_checker
    import rrts_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] status,
    input wire logic       cfg_ready
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)) else $error("result without work");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= 3'd4)) else $error("bad status");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)))
        else $error("stalled result changed");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall) else $error("cfg while busy");
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .cfg_ready(cfg_ready)
);
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the round-robin task scheduler.
`timescale 1ns / 1ps
module tb_top;
    import rrts_pkg::*;

    localparam int NSLOT  = 16;
    localparam int NSEM   = 16;
    localparam int LIMIT  = 600000;
    localparam int SETTLE = 40;

    // One scheduler event and the result word it must produce.
    typedef struct {
        op_t              op;
        logic [31:0]      delay;
        logic [3:0]       sem;
        logic [14:0]      pid;
    } sched_event_t;

    typedef struct {
        status_t          status;
        logic [14:0]      cur_pid;
        logic             switched;
        logic             started;
        logic [14:0]      new_pid;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = '0;
    logic [31:0] delay_ms = '0;
    logic [3:0]  sem_index = '0;
    logic [14:0] target_pid = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [14:0] current_pid;
    logic        switched;
    logic        started_new;
    logic [14:0] new_pid;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    sched_event_t  pending_events[$];
    sched_result_t due_results[$];
    int            errors = 0;
    int            cycles = 0;
    bit            calm = 1'b0;

    // Shadow copy of the scheduler state.
    bit          mt_on;
    bit          used_q[NSLOT];
    logic [2:0]  mode_q[NSLOT];
    logic [31:0] wake_q[NSLOT];
    logic [3:0]  blk_q[NSLOT];
    logic [14:0] pid_q[NSLOT];
    logic [3:0]  link_q[NSLOT];
    logic [3:0]  cur_q;
    bit          have_q;
    bit          sem_q[NSEM];
    logic [31:0] now_q;
    logic [14:0] last_pid_q;

    round_robin_task_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .delay_ms(delay_ms), .sem_index(sem_index),
        .target_pid(target_pid),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .current_pid(current_pid), .switched(switched),
        .started_new(started_new), .new_pid(new_pid),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit pid_live(logic [14:0] p);
        for (int i = 0; i < NSLOT; i++)
            if (used_q[i] && pid_q[i] == p)
                return 1'b1;
        return 1'b0;
    endfunction

    // Walk the ring from the task after the current one.
    function automatic status_t ring_yield(ref bit started);
        logic [3:0] t;
        if (!have_q)
            return ST_NONE_RUN;
        if (!mt_on)
            return ST_OK;
        t = link_q[cur_q];
        for (int n = 0; n < NSLOT; n++)
        begin
            if (mode_q[t] == MODE_RUN || mode_q[t] == MODE_NEW ||
                (mode_q[t][1] && !sem_q[blk_q[t]]))
            begin
                if (mode_q[t] == MODE_NEW)
                    started = 1'b1;
                mode_q[t] = MODE_RUN;
                cur_q = t;
                return ST_OK;
            end
            t = link_q[t];
        end
        return ST_NONE_RUN;
    endfunction

    function automatic sched_result_t predict_schedule(sched_event_t ev);
        sched_result_t r;
        bit            had;
        logic [3:0]    prev;
        bit            started;
        int            s;
        int            t;
        logic [3:0]    p;
        had = have_q;
        prev = cur_q;
        started = 1'b0;
        r.status = ST_OK;
        r.new_pid = '0;
        case (ev.op)
            OP_TICK:
            begin
                now_q = now_q + 32'd1;
                if (mt_on)
                    for (int i = 0; i < NSLOT; i++)
                        if (used_q[i] && mode_q[i][2] && now_q >= wake_q[i])
                            mode_q[i] = MODE_RUN;
            end
            OP_YIELD: r.status = ring_yield(started);
            OP_SLEEP:
            begin
                if (have_q)
                begin
                    wake_q[cur_q] = now_q + ev.delay;
                    mode_q[cur_q] = MODE_WAIT;
                end
                r.status = ring_yield(started);
            end
            OP_OBTAIN, OP_OBTAIN_TO:
            begin
                sem_q[ev.sem] = 1'b1;
                if (have_q)
                begin
                    blk_q[cur_q] = ev.sem;
                    if (ev.op == OP_OBTAIN_TO)
                    begin
                        wake_q[cur_q] = now_q + ev.delay;
                        mode_q[cur_q] = MODE_BTO;
                    end
                    else
                        mode_q[cur_q] = MODE_BLOCK;
                end
                r.status = ring_yield(started);
            end
            OP_RELEASE:
            begin
                r.status = ring_yield(started);
                sem_q[ev.sem] = 1'b0;
            end
            OP_CREATE:
            begin
                s = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!used_q[i])
                        s = i;
                if (s < 0)
                    r.status = ST_FULL;
                else
                begin
                    if (last_pid_q != 0)
                    begin
                        for (int i = 0; i <= NSLOT; i++)
                        begin
                            last_pid_q = (last_pid_q == PID_MAX) ? 15'd1 : last_pid_q + 15'd1;
                            if (!pid_live(last_pid_q))
                                break;
                        end
                    end
                    else
                        last_pid_q = 15'd1;
                    used_q[s] = 1'b1;
                    mode_q[s] = MODE_NEW;
                    wake_q[s] = '0;
                    blk_q[s] = '0;
                    pid_q[s] = last_pid_q;
                    if (!have_q)
                    begin
                        cur_q = s[3:0];
                        link_q[s] = s[3:0];
                        have_q = 1'b1;
                    end
                    else
                    begin
                        link_q[s] = link_q[cur_q];
                        link_q[cur_q] = s[3:0];
                    end
                    r.new_pid = last_pid_q;
                end
            end
            default:
            begin
                t = -1;
                if (ev.pid != 0)
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (used_q[i] && pid_q[i] == ev.pid)
                            t = i;
                if (t < 0)
                    r.status = ST_NOT_FOUND;
                else if (link_q[t] == t[3:0])
                    r.status = ST_LAST_KEPT;
                else
                begin
                    p = t[3:0];
                    for (int n = 0; n < NSLOT && link_q[p] != t[3:0]; n++)
                        p = link_q[p];
                    link_q[p] = link_q[t];
                    used_q[t] = 1'b0;
                    if (cur_q == t[3:0])
                    begin
                        cur_q = link_q[p];
                        if (mode_q[cur_q] == MODE_NEW)
                        begin
                            mode_q[cur_q] = MODE_RUN;
                            started = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.cur_pid = have_q ? pid_q[cur_q] : '0;
        r.switched = (had != have_q) || (have_q && prev != cur_q);
        r.started = started;
        return r;
    endfunction

    // Driver: present the next queued word, or idle, whenever the port is free.
    always @(posedge clk or negedge rst_n)
    begin
        sched_event_t ev;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                ev.op = op_t'(opcode);
                ev.delay = delay_ms;
                ev.sem = sem_index;
                ev.pid = target_pid;
                due_results.push_back(predict_schedule(ev));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_events.size() > 0 && (calm || $urandom_range(0, 99) >= 31))
                begin
                    ev = pending_events.pop_front();
                    in_valid <= 1'b1;
                    opcode <= ev.op;
                    delay_ms <= ev.delay;
                    sem_index <= ev.sem;
                    target_pid <= ev.pid;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, compare every taken word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t x;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    x = due_results.pop_front();
                    if (status !== x.status)
                    begin
                        $error("status: expected %0d, got %0d", x.status, status);
                        errors++;
                    end
                    if (current_pid !== x.cur_pid)
                    begin
                        $error("current_pid: expected %0d, got %0d", x.cur_pid, current_pid);
                        errors++;
                    end
                    if (switched !== x.switched)
                    begin
                        $error("switched: expected %0d, got %0d", x.switched, switched);
                        errors++;
                    end
                    if (started_new !== x.started)
                    begin
                        $error("started_new: expected %0d, got %0d", x.started, started_new);
                        errors++;
                    end
                    if (new_pid !== x.new_pid)
                    begin
                        $error("new_pid: expected %0d, got %0d", x.new_pid, new_pid);
                        errors++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 31);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_event(op_t op, logic [31:0] d, logic [3:0] s, logic [14:0] p);
        sched_event_t ev;
        ev.op = op;
        ev.delay = d;
        ev.sem = s;
        ev.pid = p;
        pending_events.push_back(ev);
    endtask

    task automatic queue_random(int count);
        op_t         op;
        logic [31:0] d;
        logic [3:0]  s;
        logic [14:0] p;
        int          roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25) op = OP_TICK;
            else if (roll < 40) op = OP_YIELD;
            else if (roll < 50) op = OP_SLEEP;
            else if (roll < 58) op = OP_OBTAIN;
            else if (roll < 66) op = OP_OBTAIN_TO;
            else if (roll < 78) op = OP_RELEASE;
            else if (roll < 90) op = OP_CREATE;
            else op = OP_KILL;
            d = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 8)) : $urandom;
            s = ($urandom_range(0, 3) < 3) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            p = ($urandom_range(0, 4) < 4) ? 15'($urandom_range(1, 40)) : 15'($urandom);
            queue_event(op, d, s, p);
        end
    endtask

    // Let every queued word through and every result drain.
    task automatic drain;
        while (pending_events.size() > 0 || in_valid || due_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_enable(bit v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        mt_on = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        mt_on = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            used_q[i] = 1'b0;
            mode_q[i] = '0;
            wake_q[i] = '0;
            blk_q[i] = '0;
            pid_q[i] = '0;
            link_q[i] = '0;
            sem_q[i] = 1'b0;
        end
        cur_q = '0;
        have_q = 1'b0;
        now_q = '0;
        last_pid_q = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, scheduling held off.
        write_enable(1'b0);
        queue_event(OP_YIELD, 32'd0, 4'd0, 15'd0);
        queue_event(OP_OBTAIN_TO, 32'hFFFF_FFFF, 4'd15, 15'd0);
        queue_event(OP_RELEASE, 32'd0, 4'd15, 15'd0);
        queue_event(OP_KILL, 32'd0, 4'd0, 15'd0);
        queue_event(OP_KILL, 32'd0, 4'd0, 15'h7FFF);
        queue_event(OP_CREATE, 32'd0, 4'd0, 15'd0);
        queue_event(OP_YIELD, 32'd0, 4'd0, 15'd0);
        queue_event(OP_TICK, 32'd0, 4'd0, 15'd0);
        drain();

        // Fill the table past full, kill the current task, then sleep, obtain, release and tick.
        write_enable(1'b1);
        repeat (16) queue_event(OP_CREATE, 32'd0, 4'd0, 15'd0);
        queue_event(OP_KILL, 32'd0, 4'd0, 15'd1);
        queue_event(OP_SLEEP, 32'hFFFF_FFFF, 4'd0, 15'd0);
        queue_event(OP_OBTAIN_TO, 32'd2, 4'd3, 15'd0);
        queue_event(OP_OBTAIN, 32'd0, 4'd3, 15'd0);
        queue_event(OP_RELEASE, 32'd0, 4'd3, 15'd0);
        queue_event(OP_TICK, 32'd0, 4'd0, 15'd0);
        queue_event(OP_TICK, 32'd0, 4'd0, 15'd0);
        drain();

        queue_random(220);
        drain();

        // Scheduling off, no idling on either side.
        calm = 1'b1;
        write_enable(1'b0);
        queue_random(100);
        drain();
        calm = 1'b0;

        write_enable(1'b1);
        queue_random(230);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: round_robin_task_scheduler.f
rtl/core/rrts_pkg.sv
rtl/core/round_robin_task_scheduler.sv
rtl/core/rrts_checker.sv
dv/tb_top.sv
